@@ src/adic_pkg.sv @@
// ============================================================================
// adic_pkg
// Shared types and constants for the audio DMA interrupt controller.
// ============================================================================
`default_nettype none

package adic_pkg;

    localparam int ADDR_BITS  = 29;
    localparam int COUNT_BITS = 15;
    localparam int DATA_BITS  = 16;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [DATA_BITS-1:0] FLAGS_RESET   = 16'h0004;
    localparam logic [DATA_BITS-1:0] ENABLE_BIT    = 16'h8000;
    localparam logic [DATA_BITS-1:0] FLAG_AID      = 16'h0008;
    localparam logic [DATA_BITS-1:0] FLAG_ARAM     = 16'h0020;
    localparam logic [DATA_BITS-1:0] FLAG_DSP      = 16'h0080;
    localparam logic [DATA_BITS-1:0] FLAG_ALL      = FLAG_AID | FLAG_ARAM | FLAG_DSP;
    localparam logic [DATA_BITS-1:0] DMA_STATE_BIT = 16'h0200;
    localparam logic [DATA_BITS-1:0] CTRL_DIRECT   = 16'hf000 | 16'h0800 | 16'h0400
                                                   | 16'h0100 | 16'h0040 | 16'h0010
                                                   | 16'h0004 | 16'h0002 | 16'h0001;
    localparam logic [DATA_BITS-1:0] HIGH_MASK_EXT = 16'h1fff;
    localparam logic [DATA_BITS-1:0] HIGH_MASK_STD = 16'h03ff;
    localparam logic [DATA_BITS-1:0] LOW_MASK      = 16'hffe0;
    localparam logic [ADDR_BITS-1:0] BLOCK_BYTES   = ADDR_BITS'(32);

    typedef enum logic [2:0] {
        REQ_TICK       = 3'd0,
        REQ_ADDR_HIGH  = 3'd1,
        REQ_ADDR_LOW   = 3'd2,
        REQ_DMA_CTRL   = 3'd3,
        REQ_DSP_CTRL   = 3'd4,
        REQ_READ       = 3'd5,
        REQ_EVENT      = 3'd6,
        REQ_NONE       = 3'd7
    } req_code_t;

    typedef enum logic [1:0] {
        EVT_DSP_INT    = 2'd0,
        EVT_AUX_DONE   = 2'd1,
        EVT_AUX_START  = 2'd2,
        EVT_NONE       = 2'd3
    } evt_code_t;

    localparam logic SEL_BLOCKS = 1'b0;
    localparam logic SEL_FLAGS  = 1'b1;

    localparam logic [APB_ADDR_BITS-1:0] REG_EXT_MODE = 3'd0;

    typedef struct packed {
        logic [2:0]           req_type;
        logic [DATA_BITS-1:0] write_data;
        logic                 read_select;
        logic [1:0]           event_source;
    } adic_req_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic                 fetch_valid;
        logic [ADDR_BITS-1:0] fetch_address;
        logic                 send_silence;
        logic                 irq_line;
    } adic_rsp_t;

endpackage

`default_nettype wire

@@ src/adic_core.sv @@
// ============================================================================
// adic_core
// DMA address/count sequencer and interrupt flag register; one item per cycle while fire is high.
// ============================================================================
`default_nettype none

module adic_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire adic_pkg::adic_req_t req,
    input  wire logic              ext_mode,
    output adic_pkg::adic_rsp_t    rsp
);
    import adic_pkg::*;

    logic [DATA_BITS-1:0]  flags_reg, flags_next;
    logic [ADDR_BITS-1:0]  start_reg, start_next;
    logic [DATA_BITS-1:0]  dcw_reg, dcw_next;
    logic [ADDR_BITS-1:0]  cur_reg, cur_next;
    logic [COUNT_BITS-1:0] blocks_reg, blocks_next;

    logic                  enabled;
    logic                  reload;
    logic [DATA_BITS-1:0]  high_mask;
    logic [DATA_BITS-1:0]  ctrl_val;

    assign enabled   = (dcw_reg & ENABLE_BIT) != '0;
    assign reload    = blocks_reg <= COUNT_BITS'(1);
    assign high_mask = ext_mode ? HIGH_MASK_EXT : HIGH_MASK_STD;
    assign ctrl_val  = ((flags_reg & ~CTRL_DIRECT) | (req.write_data & CTRL_DIRECT))
                     & ~(req.write_data & FLAG_ALL);

    always_comb
    begin
        flags_next  = flags_reg;
        start_next  = start_reg;
        dcw_next    = dcw_reg;
        cur_next    = cur_reg;
        blocks_next = blocks_reg;
        rsp         = '0;

        unique case (req_code_t'(req.req_type))
            REQ_TICK:
            begin
                if (enabled)
                begin
                    rsp.fetch_valid   = 1'b1;
                    rsp.fetch_address = cur_reg;
                    if (reload)
                    begin
                        cur_next    = start_reg;
                        blocks_next = dcw_reg[COUNT_BITS-1:0];
                        flags_next  = flags_reg | FLAG_AID;
                    end
                    else
                    begin
                        cur_next    = cur_reg + BLOCK_BYTES;
                        blocks_next = blocks_reg - COUNT_BITS'(1);
                    end
                end
                else
                begin
                    rsp.send_silence = 1'b1;
                end
            end
            REQ_ADDR_HIGH:
                start_next = ADDR_BITS'({req.write_data & high_mask, start_reg[15:0]});
            REQ_ADDR_LOW:
                start_next = {start_reg[ADDR_BITS-1:16], req.write_data & LOW_MASK};
            REQ_DMA_CTRL:
            begin
                dcw_next = req.write_data;
                if (!enabled && ((req.write_data & ENABLE_BIT) != '0))
                begin
                    cur_next    = start_reg;
                    blocks_next = req.write_data[COUNT_BITS-1:0];
                    flags_next  = flags_reg | FLAG_AID;
                end
            end
            REQ_DSP_CTRL:
            begin
                flags_next = ctrl_val;
                if (req.write_data[0])
                    dcw_next = '0;
            end
            REQ_READ:
            begin
                if (req.read_select == SEL_BLOCKS)
                    rsp.read_data = reload ? '0 : DATA_BITS'(blocks_reg - COUNT_BITS'(1));
                else
                    rsp.read_data = flags_reg;
            end
            REQ_EVENT:
            begin
                unique case (evt_code_t'(req.event_source))
                    EVT_DSP_INT:   flags_next = flags_reg | FLAG_DSP;
                    EVT_AUX_DONE:  flags_next = (flags_reg & ~DMA_STATE_BIT) | FLAG_ARAM;
                    EVT_AUX_START: flags_next = flags_reg | DMA_STATE_BIT;
                    default:       flags_next = flags_reg;
                endcase
            end
            default:
                flags_next = flags_reg;
        endcase

        rsp.irq_line = ((flags_next >> 1) & flags_next & FLAG_ALL) != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= FLAGS_RESET;
            start_reg  <= '0;
            dcw_reg    <= '0;
            cur_reg    <= '0;
            blocks_reg <= '0;
        end
        else if (fire)
        begin
            flags_reg  <= flags_next;
            start_reg  <= start_next;
            dcw_reg    <= dcw_next;
            cur_reg    <= cur_next;
            blocks_reg <= blocks_next;
        end
    end

    // start address stays block aligned
    a_start_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg[4:0] == 5'd0)
        else $error("start address not block aligned");

    // a fetch that exhausts the count raises the audio flag
    a_reload_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req.req_type == REQ_TICK && enabled && reload) |=> flags_reg[3])
        else $error("audio flag not raised on reload");

    a_fetch_excl: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(rsp.fetch_valid && rsp.send_silence))
        else $error("fetch and silence together");

endmodule

`default_nettype wire

@@ src/adic_out_buf.sv @@
// ============================================================================
// adic_out_buf
// Result register with a skid stage so the input side keeps flowing.
// ============================================================================
`default_nettype none

module adic_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire adic_pkg::adic_rsp_t push_item,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output adic_pkg::adic_rsp_t     out_item
);
    import adic_pkg::*;

    logic      out_valid_reg;
    logic      skid_valid_reg;
    adic_rsp_t out_item_reg;
    adic_rsp_t skid_item_reg;

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
                out_item_reg <= skid_item_reg;
            else if (push)
                out_item_reg <= push_item;
        end
        else if (push)
        begin
            skid_item_reg <= push_item;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item with output empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid item not moved forward");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("item pushed into full buffer");

endmodule

`default_nettype wire

@@ src/audio_dma_interrupt_controller.sv @@
// A result is registered, and waits in the skid stage while the output stalls.
// One item per cycle while req_stall is low; the result register plus a skid
// stage of one entry lets the next item in while a result waits on rsp_stall.
// req_stall rises only when both output slots are full.
// Reset (rst_n, async, low): flags 0x0004, address/count/control zero, mode 0.
// ============================================================================
// audio_dma_interrupt_controller
// Audio DMA block sequencer with masked interrupt flags and an APB mode reg.
// ============================================================================
`default_nettype none

module audio_dma_interrupt_controller (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  req_valid,
    output logic                                       req_stall,
    input  wire adic_pkg::adic_req_t                   req,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_stall,
    output adic_pkg::adic_rsp_t                        rsp,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [adic_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire logic [adic_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [adic_pkg::APB_DATA_BITS-1:0]         prdata,
    output logic                                       pready
);
    import adic_pkg::*;

    logic      ext_mode_reg;
    logic      sel_ext;
    logic      fire;
    logic      buf_full;
    adic_rsp_t core_rsp;

    assign pready  = 1'b1;
    assign sel_ext = (paddr & ~APB_ADDR_BITS'(3)) == REG_EXT_MODE;
    assign prdata  = sel_ext ? APB_DATA_BITS'(ext_mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ext_mode_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && sel_ext)
            ext_mode_reg <= pwdata[0];
    end

    assign req_stall = buf_full;
    assign fire      = req_valid && !buf_full;

    adic_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req      (req),
        .ext_mode (ext_mode_reg),
        .rsp      (core_rsp)
    );

    adic_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_item (core_rsp),
        .full      (buf_full),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_item  (rsp)
    );

endmodule

`default_nettype wire
